FILE: hdl/heap_sort_engine_unit_defines.svh
// assertion macros for the heap sort engine checker
`ifndef HEAP_SORT_ENGINE_UNIT_DEFINES_SVH
`define HEAP_SORT_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/hse_pkg.sv
package hse_pkg;

    localparam int HSE_MAX_ITEMS = 64;
    localparam int HSE_DATA_W    = 32;

endpackage

FILE: hdl/hse_ram.sv
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/heap_sort_engine_unit.sv
// Heap sort engine. Words are collected one per cycle into a single-port-read
// store of MAX_ITEMS entries until a word with is_last arrives; words that find
// the store full are discarded and every result of that set then carries
// dropped. The set is sorted in place by a sequencer around one signed
// comparator and the store's single read port: each sift-down level issues
// the left child read, compares the left child, then compares the right child
// and writes back; each extraction first swaps root and last entry, and the
// bottom-up build loads each node before sifting it down. Results then leave in
// ascending order behind an output register, each fetched only after the one
// before it has been taken; item_stall stays high from the last word until the
// greatest result has been taken.
module heap_sort_engine_unit
    import hse_pkg::*;
#(
    parameter int MAX_ITEMS = HSE_MAX_ITEMS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [HSE_DATA_W-1:0] value,
    input  logic                         is_last,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [HSE_DATA_W-1:0] sorted_value,
    output logic                         is_last_res,
    output logic                         dropped
);

    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_B_NEXT,
        S_LD,
        S_CHK,
        S_RDL,
        S_RDR,
        S_X_NEXT,
        S_X1,
        S_X2,
        S_E_RD,
        S_E_WAIT,
        S_E_HOLD
    } state_t;

    state_t                  state_reg, state_next;
    logic                    extract_reg, extract_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        bi_reg, bi_next;
    logic [CNT_W-1:0]        xi_reg, xi_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic [CNT_W-1:0]        size_reg, size_next;
    logic [ADDR_W-1:0]       node_reg, node_next;
    logic [ADDR_W-1:0]       best_idx_reg, best_idx_next;
    logic [HSE_DATA_W-1:0]   cur_reg, cur_next;
    logic [HSE_DATA_W-1:0]   tmp_reg, tmp_next;
    logic [HSE_DATA_W-1:0]   best_val_reg, best_val_next;
    logic                    res_valid_reg, res_valid_next;
    logic [HSE_DATA_W-1:0]   sorted_value_reg, sorted_value_next;
    logic                    is_last_res_reg, is_last_res_next;
    logic                    dropped_reg, dropped_next;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [HSE_DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [HSE_DATA_W-1:0]   ram_rdata;

    logic [CHILD_W-1:0]      left_idx;
    logic [CHILD_W-1:0]      right_idx;
    logic                    left_in;
    logic                    right_in;
    logic [HSE_DATA_W-1:0]   cmp_b;
    logic                    cmp_gt;
    logic [CNT_W-1:0]        cnt_after;
    logic [HSE_DATA_W-1:0]   fin_val;
    logic [ADDR_W-1:0]       fin_idx;

    hse_ram #(
        .WIDTH (HSE_DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign left_idx  = {1'b0, node_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign left_in   = left_idx < CHILD_W'(size_reg);
    assign right_in  = right_idx < CHILD_W'(size_reg);

    // shared signed comparator
    assign cmp_b  = (state_reg == S_RDL) ? cur_reg : best_val_reg;
    assign cmp_gt = $signed(ram_rdata) > $signed(cmp_b);

    assign cnt_after = (cnt_reg < CNT_W'(MAX_ITEMS)) ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        if (right_in && cmp_gt)
        begin
            fin_val = ram_rdata;
            fin_idx = right_idx[ADDR_W-1:0];
        end
        else
        begin
            fin_val = best_val_reg;
            fin_idx = best_idx_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        extract_next      = extract_reg;
        cnt_next          = cnt_reg;
        ovf_next          = ovf_reg;
        n_next            = n_reg;
        bi_next           = bi_reg;
        xi_next           = xi_reg;
        k_next            = k_reg;
        size_next         = size_reg;
        node_next         = node_reg;
        best_idx_next     = best_idx_reg;
        cur_next          = cur_reg;
        tmp_next          = tmp_reg;
        best_val_next     = best_val_reg;
        res_valid_next    = res_valid_reg;
        sorted_value_next = sorted_value_reg;
        is_last_res_next  = is_last_res_reg;
        dropped_next      = dropped_reg;
        ram_we            = 1'b0;
        ram_waddr         = node_reg;
        ram_wdata         = cur_reg;
        ram_raddr         = node_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (cnt_reg < CNT_W'(MAX_ITEMS))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_reg[ADDR_W-1:0];
                        ram_wdata = value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = cnt_after;
                    if (is_last)
                    begin
                        n_next       = cnt_after;
                        bi_next      = cnt_after >> 1;
                        extract_next = 1'b0;
                        state_next   = S_B_NEXT;
                    end
                end
            end
            S_B_NEXT:
            begin
                if (bi_reg == '0)
                begin
                    xi_next      = n_reg;
                    extract_next = 1'b1;
                    state_next   = S_X_NEXT;
                end
                else
                begin
                    node_next  = ADDR_W'(bi_reg - 1'b1);
                    ram_raddr  = ADDR_W'(bi_reg - 1'b1);
                    bi_next    = bi_reg - 1'b1;
                    size_next  = n_reg;
                    state_next = S_LD;
                end
            end
            S_LD:
            begin
                cur_next   = ram_rdata;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!left_in)
                begin
                    ram_we     = 1'b1;
                    state_next = extract_reg ? S_X_NEXT : S_B_NEXT;
                end
                else
                begin
                    ram_raddr  = left_idx[ADDR_W-1:0];
                    state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                ram_raddr = right_idx[ADDR_W-1:0];
                if (cmp_gt)
                begin
                    best_val_next = ram_rdata;
                    best_idx_next = left_idx[ADDR_W-1:0];
                end
                else
                begin
                    best_val_next = cur_reg;
                    best_idx_next = node_reg;
                end
                state_next = S_RDR;
            end
            S_RDR:
            begin
                ram_we = 1'b1;
                if (fin_idx == node_reg)
                begin
                    state_next = extract_reg ? S_X_NEXT : S_B_NEXT;
                end
                else
                begin
                    ram_wdata  = fin_val;
                    node_next  = fin_idx;
                    state_next = S_CHK;
                end
            end
            S_X_NEXT:
            begin
                if (xi_reg <= CNT_W'(1))
                begin
                    k_next     = '0;
                    state_next = S_E_RD;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = S_X1;
                end
            end
            S_X1:
            begin
                tmp_next   = ram_rdata;
                ram_raddr  = ADDR_W'(xi_reg - 1'b1);
                state_next = S_X2;
            end
            S_X2:
            begin
                cur_next   = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = ADDR_W'(xi_reg - 1'b1);
                ram_wdata  = tmp_reg;
                size_next  = xi_reg - 1'b1;
                xi_next    = xi_reg - 1'b1;
                node_next  = '0;
                state_next = S_CHK;
            end
            S_E_RD:
            begin
                ram_raddr  = k_reg[ADDR_W-1:0];
                state_next = S_E_WAIT;
            end
            S_E_WAIT:
            begin
                res_valid_next    = 1'b1;
                sorted_value_next = ram_rdata;
                is_last_res_next  = (k_reg + 1'b1) == n_reg;
                dropped_next      = ovf_reg;
                state_next        = S_E_HOLD;
            end
            S_E_HOLD:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    if (is_last_res_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_E_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            extract_reg      <= 1'b0;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            n_reg            <= '0;
            bi_reg           <= '0;
            xi_reg           <= '0;
            k_reg            <= '0;
            size_reg         <= '0;
            node_reg         <= '0;
            res_valid_reg    <= 1'b0;
            sorted_value_reg <= '0;
            is_last_res_reg  <= 1'b0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            extract_reg      <= extract_next;
            cnt_reg          <= cnt_next;
            ovf_reg          <= ovf_next;
            n_reg            <= n_next;
            bi_reg           <= bi_next;
            xi_reg           <= xi_next;
            k_reg            <= k_next;
            size_reg         <= size_next;
            node_reg         <= node_next;
            res_valid_reg    <= res_valid_next;
            sorted_value_reg <= sorted_value_next;
            is_last_res_reg  <= is_last_res_next;
            dropped_reg      <= dropped_next;
        end
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        cur_reg      <= cur_next;
        tmp_reg      <= tmp_next;
        best_val_reg <= best_val_next;
    end

    assign item_stall   = state_reg != S_IDLE;
    assign res_valid    = res_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign is_last_res  = is_last_res_reg;
    assign dropped      = dropped_reg;

endmodule

FILE: hdl/hse_checker.sv
`include "heap_sort_engine_unit_defines.svh"

module hse_checker
    import hse_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  is_last,
    input logic                  res_valid,
    input logic                  res_stall,
    input logic [HSE_DATA_W-1:0] sorted_value,
    input logic                  is_last_res
);

    // no new word is taken while results are pending
    `HSE_ASSERT_NOW(a_busy_out, res_valid, item_stall, "word accepted while emitting")

    // the last word of a set starts the sort
    `HSE_ASSERT_NEXT(a_last_busy, item_valid && !item_stall && is_last, item_stall, "sort not started")

    // an ordinary word leaves the block ready
    `HSE_ASSERT_NEXT(a_word_ready, item_valid && !item_stall && !is_last, !item_stall, "stalled after word")

    // final result taken returns the block to idle
    `HSE_ASSERT_NEXT(a_set_done, res_valid && !res_stall && is_last_res, !res_valid && !item_stall, "not idle after set")

    // stalled result holds
    `HSE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(sorted_value), "result changed under stall")

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (.*);
